// ===== design/spwt_pkg.sv =====
// Shared types and constants for the signed pulse width thermometer.
// Used by spwt_meas, spwt_scale and signed_pulse_width_thermometer.
package spwt_pkg;

  // Register widths and indexes of the configuration port
  localparam int IdleTimeoutW = 16;
  localparam int MaxWidthW    = 14;
  localparam int CfgIndexW    = 1;
  localparam int CfgDataW     = 16;

  localparam logic [CfgIndexW-1:0] REG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CfgIndexW-1:0] REG_MAX_WIDTH    = 1'd1;

  localparam logic [IdleTimeoutW-1:0] IDLE_TIMEOUT_RST = 16'd65000;
  localparam logic [MaxWidthW-1:0]    MAX_WIDTH_RST    = 14'd10000;

  // Counter and field widths
  localparam int IdleCountW = 17;
  localparam int MagW       = 12;
  localparam int DutyW      = 7;

  // Scale by 19/100: floor(width * 19 / 100) == (width * ScaleMul) >> ScaleShift
  // for every 14-bit width (rounding error stays below 1/100 of one step).
  localparam int ScaleShift = 24;
  localparam int ScaleMulW  = 22;
  localparam logic [ScaleMulW-1:0] ScaleMul = 22'd3187672;
  localparam int ProdW = MaxWidthW + ScaleMulW;

  // Heater duty steps and magnitude thresholds
  localparam logic [DutyW-1:0] DUTY_OFF  = 7'd0;
  localparam logic [DutyW-1:0] DUTY_MIN  = 7'd10;
  localparam logic [DutyW-1:0] DUTY_LOW  = 7'd20;
  localparam logic [DutyW-1:0] DUTY_MID  = 7'd50;
  localparam logic [DutyW-1:0] DUTY_HIGH = 7'd80;
  localparam logic [DutyW-1:0] DUTY_MAX  = 7'd100;

  localparam logic [MagW-1:0] MAG_STEP1 = 12'd5;
  localparam logic [MagW-1:0] MAG_STEP2 = 12'd10;
  localparam logic [MagW-1:0] MAG_STEP3 = 12'd20;
  localparam logic [MagW-1:0] MAG_STEP4 = 12'd30;

  // Raw measurement event from the pulse tracker
  typedef struct packed {
    logic                 valid;
    logic [MaxWidthW-1:0] width;
    logic                 negative;
    logic                 error;
  } meas_evt_t;

  // Finished result fields
  typedef struct packed {
    logic [DutyW-1:0] heater_duty;
    logic             error;
    logic             negative;
    logic [MagW-1:0]  magnitude;
  } result_t;

endpackage

// ===== design/signed_pulse_width_thermometer.sv =====
// A sample is first captured in the sample register, then its result (if any)
// is written to the output register when the pipeline next advances.
// One sample per clock is taken while the output register is empty or being
// drained; the sample and result registers move together in that case.
// Reset (rst, synchronous): waiting phase, counters cleared, registers back
// to idle_timeout 65000 and max_width 10000, no result pending.
module signed_pulse_width_thermometer
  import spwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] plus_active, [1] minus_active
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [11:0] magnitude, [12] negative,
                                          // [13] error, [20:14] heater_duty
  input  logic                 cfg_wen,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  logic [IdleTimeoutW-1:0] idle_timeout;
  logic [MaxWidthW-1:0]    max_width;
  logic                    advance;
  meas_evt_t               evt;
  result_t                 res;
  result_t                 out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
      max_width    <= MAX_WIDTH_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT: idle_timeout <= cfg_wdata[IdleTimeoutW-1:0];
        REG_MAX_WIDTH:    max_width    <= cfg_wdata[MaxWidthW-1:0];
        default:          ;
      endcase
    end
  end

  // Move the whole pipeline when the result slot is free or draining
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  spwt_meas u_meas (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (s_tvalid),
    .in_plus      (s_tdata[0]),
    .in_minus     (s_tdata[1]),
    .idle_timeout (idle_timeout),
    .max_width    (max_width),
    .evt          (evt)
  );

  spwt_scale u_scale (
    .evt (evt),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.heater_duty, out_res.error, out_res.negative,
                    out_res.magnitude};

  // An error result is negative with zero magnitude
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.error |-> out_res.negative && out_res.magnitude == '0)
    else $error("error result not negative with zero magnitude");

  // Magnitude never exceeds the scaled longest pulse
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_res.magnitude <= 12'd3112)
    else $error("magnitude out of range");

  // Positive readings never drive the heater
  a_duty_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.negative |-> out_res.heater_duty == DUTY_OFF)
    else $error("heater duty set on positive reading");

  // A held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_res))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ===== design/spwt_meas.sv =====
// Input sample register and pulse tracking state (idle wait, sign latch,
// width count). Depends on spwt_pkg.
module spwt_meas
  import spwt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic                    in_plus,
  input  logic                    in_minus,
  input  logic [IdleTimeoutW-1:0] idle_timeout,
  input  logic [MaxWidthW-1:0]    max_width,
  output meas_evt_t               evt
);

  logic                  smp_valid;
  logic                  smp_plus;
  logic                  smp_minus;
  logic                  measuring;
  logic                  measuring_next;
  logic [IdleCountW-1:0] idle_count;
  logic [IdleCountW-1:0] idle_count_next;
  logic [MaxWidthW-1:0]  width_count;
  logic [MaxWidthW-1:0]  width_count_next;
  logic                  sign_latch;
  logic                  sign_latch_next;
  logic                  idle;
  logic [IdleCountW-1:0] idle_inc;
  logic [MaxWidthW-1:0]  width_inc;

  // Capture one sample per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (advance) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      smp_plus  <= in_plus;
      smp_minus <= in_minus;
    end
  end

  assign idle      = !smp_plus && !smp_minus;
  assign idle_inc  = idle_count + 1'b1;
  assign width_inc = width_count + 1'b1;

  // Track the waiting and measuring phases for the held sample
  always_comb begin
    measuring_next   = measuring;
    idle_count_next  = idle_count;
    width_count_next = width_count;
    sign_latch_next  = sign_latch;
    evt              = '0;
    if (smp_valid) begin
      if (!measuring) begin
        if (idle) begin
          idle_count_next = idle_inc;
          if (idle_inc > {1'b0, idle_timeout}) begin
            idle_count_next = '0;
            evt.valid       = 1'b1;
            evt.negative    = 1'b1;
            evt.error       = 1'b1;
          end
        end else begin
          measuring_next   = 1'b1;
          sign_latch_next  = smp_minus;
          width_count_next = '0;
          idle_count_next  = '0;
        end
      end else begin
        width_count_next = width_inc;
        priority if (idle && width_inc <= max_width && width_inc != '0) begin
          measuring_next   = 1'b0;
          width_count_next = '0;
          evt.valid        = 1'b1;
          evt.width        = width_inc;
          evt.negative     = sign_latch;
        end else if (width_inc >= max_width || width_inc == '0) begin
          measuring_next   = 1'b0;
          width_count_next = '0;
          evt.valid        = 1'b1;
          evt.negative     = sign_latch;
        end else begin
          measuring_next = 1'b1;
        end
      end
    end
  end

  // Advance the tracker state when the sample moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring   <= 1'b0;
      idle_count  <= '0;
      width_count <= '0;
      sign_latch  <= 1'b0;
    end else if (advance) begin
      measuring   <= measuring_next;
      idle_count  <= idle_count_next;
      width_count <= width_count_next;
      sign_latch  <= sign_latch_next;
    end
  end

endmodule

// ===== design/spwt_scale.sv =====
// Scales a pulse width by 19/100 and derives the heater duty step.
// Depends on spwt_pkg.
module spwt_scale
  import spwt_pkg::*;
(
  input  meas_evt_t evt,
  output result_t   res
);

  logic [ProdW-1:0] prod;
  logic [MagW-1:0]  mag;

  // Divide by 100 through a reciprocal multiply
  assign prod = ProdW'(evt.width) * ProdW'(ScaleMul);
  assign mag  = prod[ScaleShift +: MagW];

  // Pick the duty step for negative readings (off for positive ones)
  always_comb begin
    res.magnitude = mag;
    res.negative  = evt.negative;
    res.error     = evt.error;
    priority if (!evt.negative) begin
      res.heater_duty = DUTY_OFF;
    end else if (mag > MAG_STEP4) begin
      res.heater_duty = DUTY_MAX;
    end else if (mag > MAG_STEP3) begin
      res.heater_duty = DUTY_HIGH;
    end else if (mag > MAG_STEP2) begin
      res.heater_duty = DUTY_MID;
    end else if (mag > MAG_STEP1) begin
      res.heater_duty = DUTY_LOW;
    end else begin
      res.heater_duty = DUTY_MIN;
    end
  end

endmodule
